[rtl/mrf_pkg.sv]
package mrf_pkg;

	localparam int unsigned MAX_COILS     = 1968;
	localparam int unsigned MAX_REGISTERS = 123;

	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [15:0] CRC_POLY     = 16'hA001;
	localparam logic [15:0] COIL_ON_WORD = 16'hFF00;

	localparam int unsigned JOB_BYTES = 7;

	// request type codes on the input channel
	typedef enum logic [3:0] {
		REQ_RD_COILS    = 4'd0,
		REQ_RD_DISCRETE = 4'd1,
		REQ_RD_HOLDING  = 4'd2,
		REQ_RD_INPUT    = 4'd3,
		REQ_WR_COIL     = 4'd4,
		REQ_WR_REG      = 4'd5,
		REQ_WR_COILS    = 4'd6,
		REQ_WR_REGS     = 4'd7,
		REQ_DATA        = 4'd8
	} req_type_t;

	// modbus function codes
	localparam logic [7:0] FC_RD_COILS    = 8'h01;
	localparam logic [7:0] FC_RD_DISCRETE = 8'h02;
	localparam logic [7:0] FC_RD_HOLDING  = 8'h03;
	localparam logic [7:0] FC_RD_INPUT    = 8'h04;
	localparam logic [7:0] FC_WR_COIL     = 8'h05;
	localparam logic [7:0] FC_WR_REG      = 8'h06;
	localparam logic [7:0] FC_WR_COILS    = 8'h0F;
	localparam logic [7:0] FC_WR_REGS     = 8'h10;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_COILS = 2'd1,
		KIND_REGS  = 2'd2
	} frame_kind_t;

	// one unit of work for the byte emitter
	typedef struct packed {
		logic                            err;
		logic                            crc_init;
		logic                            crc_append;
		logic [2:0]                      nbytes;
		logic [JOB_BYTES-1:0][7:0]       bytes;
	} job_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

[rtl/mrf_front.sv]
module mrf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [3:0]          req_type,
	input  logic [7:0]          slave_addr,
	input  logic [15:0]         start_address,
	input  logic [15:0]         quantity,
	input  logic [15:0]         write_value,
	input  logic                coil_on,
	input  logic [15:0]         data_word,
	output logic                job_valid,
	input  logic                job_ready,
	output mrf_pkg::job_t       job
);

	mrf_pkg::frame_kind_t open_kind_q, open_kind_d;
	logic [10:0]          elements_left_q, elements_left_d;

	logic        is_multi;
	logic        qty_ok;
	logic [7:0]  fc;
	logic [15:0] word;
	logic [7:0]  cnt;
	logic [10:0] elem;
	logic [16:0] qsum;
	logic [10:0] coil_bytes;
	logic [10:0] elem_dec;
	logic        accept;

	assign in_ready  = job_ready;
	assign job_valid = in_valid;
	assign accept    = in_valid && job_ready;

	// (quantity + 7) / 8, only used when quantity is within the coil limit
	assign qsum       = {1'b0, quantity} + 17'd7;
	assign coil_bytes = qsum[13:3];
	assign elem_dec   = elements_left_q - 11'd1;

	always_comb begin
		is_multi        = 1'b0;
		qty_ok          = 1'b1;
		fc              = mrf_pkg::FC_RD_COILS;
		word            = quantity;
		cnt             = 8'h00;
		elem            = '0;
		open_kind_d     = open_kind_q;
		elements_left_d = elements_left_q;
		job             = '0;
		job.crc_init    = 1'b1;
		job.crc_append  = 1'b1;
		job.nbytes      = 3'd6;
		case (req_type)
			mrf_pkg::REQ_RD_COILS:    fc = mrf_pkg::FC_RD_COILS;
			mrf_pkg::REQ_RD_DISCRETE: fc = mrf_pkg::FC_RD_DISCRETE;
			mrf_pkg::REQ_RD_HOLDING:  fc = mrf_pkg::FC_RD_HOLDING;
			mrf_pkg::REQ_RD_INPUT:    fc = mrf_pkg::FC_RD_INPUT;
			mrf_pkg::REQ_WR_COIL: begin
				fc   = mrf_pkg::FC_WR_COIL;
				word = coil_on ? mrf_pkg::COIL_ON_WORD : 16'h0000;
			end
			mrf_pkg::REQ_WR_REG: begin
				fc   = mrf_pkg::FC_WR_REG;
				word = write_value;
			end
			mrf_pkg::REQ_WR_COILS: begin
				is_multi = 1'b1;
				fc       = mrf_pkg::FC_WR_COILS;
				qty_ok   = (quantity != 16'd0) && (quantity <= 16'(mrf_pkg::MAX_COILS));
				cnt      = coil_bytes[7:0];
				elem     = coil_bytes;
			end
			mrf_pkg::REQ_WR_REGS: begin
				is_multi = 1'b1;
				fc       = mrf_pkg::FC_WR_REGS;
				qty_ok   = (quantity != 16'd0) && (quantity <= 16'(mrf_pkg::MAX_REGISTERS));
				cnt      = {quantity[6:0], 1'b0};
				elem     = quantity[10:0];
			end
			default: qty_ok = 1'b0;
		endcase

		if (req_type == mrf_pkg::REQ_DATA) begin
			job.crc_init   = 1'b0;
			job.crc_append = 1'b0;
			if (open_kind_q == mrf_pkg::KIND_NONE) begin
				job.err = 1'b1;
			end else begin
				if (open_kind_q == mrf_pkg::KIND_COILS) begin
					job.nbytes   = 3'd1;
					job.bytes[0] = data_word[7:0];
				end else begin
					job.nbytes   = 3'd2;
					job.bytes[0] = data_word[15:8];
					job.bytes[1] = data_word[7:0];
				end
				elements_left_d = elem_dec;
				// count exhausted: close the frame with its crc
				if (elem_dec == '0) begin
					job.crc_append = 1'b1;
					open_kind_d    = mrf_pkg::KIND_NONE;
				end
			end
		end else if (!qty_ok) begin
			job.err = 1'b1;
		end else begin
			job.bytes[0]   = slave_addr;
			job.bytes[1]   = fc;
			job.bytes[2]   = start_address[15:8];
			job.bytes[3]   = start_address[7:0];
			job.bytes[4]   = word[15:8];
			job.bytes[5]   = word[7:0];
			job.bytes[6]   = cnt;
			job.nbytes     = is_multi ? 3'd7 : 3'd6;
			job.crc_append = !is_multi;
			elements_left_d = elem;
			if (!is_multi) begin
				open_kind_d = mrf_pkg::KIND_NONE;
			end else if (req_type == mrf_pkg::REQ_WR_COILS) begin
				open_kind_d = mrf_pkg::KIND_COILS;
			end else begin
				open_kind_d = mrf_pkg::KIND_REGS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_kind_q     <= mrf_pkg::KIND_NONE;
			elements_left_q <= '0;
		end else if (accept) begin
			open_kind_q     <= open_kind_d;
			elements_left_q <= elements_left_d;
		end
	end

	a_none_means_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(open_kind_q == mrf_pkg::KIND_NONE) |-> (elements_left_q == '0))
		else $error("no frame open but elements still due");

	a_open_means_due: assert property (@(posedge clk) disable iff (!arst_n)
		(open_kind_q != mrf_pkg::KIND_NONE) |-> (elements_left_q != '0))
		else $error("frame open with nothing due");

endmodule

[rtl/mrf_queue.sv]
module mrf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  mrf_pkg::job_t wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output mrf_pkg::job_t rd_data
);

	mrf_pkg::job_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          push;
	logic          pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = entry_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

[rtl/mrf_back.sv]
module mrf_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_ready,
	input  mrf_pkg::job_t job,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    frame_byte,
	output logic          last_byte,
	output logic          error
);

	logic [3:0]  idx_q;
	logic [15:0] crc_q;
	logic        out_valid_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic        err_q;

	logic        advance;
	logic        done;
	logic [7:0]  byte_d;
	logic        last_d;
	logic [15:0] crc_base;
	logic [15:0] crc_d;
	logic [3:0]  nb;

	assign advance   = job_valid && (!out_valid_q || out_ready);
	assign job_ready = advance && done;
	assign nb        = {1'b0, job.nbytes};
	assign crc_base  = (idx_q == 4'd0 && job.crc_init) ? mrf_pkg::CRC_INIT : crc_q;

	always_comb begin
		byte_d = 8'h00;
		last_d = 1'b0;
		crc_d  = crc_q;
		done   = 1'b0;
		if (job.err) begin
			last_d = 1'b1;
			done   = 1'b1;
		end else if (idx_q < nb) begin
			byte_d = job.bytes[idx_q[2:0]];
			crc_d  = mrf_pkg::crc_feed(crc_base, byte_d);
			done   = (idx_q == nb - 4'd1) && !job.crc_append;
		end else if (idx_q == nb) begin
			byte_d = crc_q[7:0];
		end else begin
			byte_d = crc_q[15:8];
			last_d = 1'b1;
			crc_d  = mrf_pkg::CRC_INIT;
			done   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			crc_q       <= mrf_pkg::CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				idx_q       <= done ? 4'd0 : idx_q + 4'd1;
				crc_q       <= crc_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output register parts the emitter from the sink
	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q <= byte_d;
			last_q <= last_d;
			err_q  <= job.err;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = byte_q;
	assign last_byte  = last_q;
	assign error      = err_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= 4'd8)
		else $error("byte index past end of frame");

	a_idle_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!job_valid |-> (idx_q == 4'd0))
		else $error("partial job with empty queue");

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && err_q) |-> (last_q && byte_q == 8'h00))
		else $error("error result not a lone zero byte");

endmodule

[rtl/modbus_rtu_request_framer.sv]
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_ready | req_type slave_addr start_address quantity
//         |           |                     | write_value coil_on data_word
// out     | output    | out_valid/out_ready | frame_byte last_byte error
//
// one frame byte per cycle from the byte emitter if out is ready: a single request 8 bytes,
// a multi-write header 7, a data item 1 or 2, plus 2 for the crc on the closing item.
// the front classifies an item in the cycle it arrives and parks it in a 2-entry queue.
// out has a registered stage, so a stalled sink stops the emitter but the queue still fills.
// arst_n clears the open frame, the queue and the output valid; crc restarts at 0xFFFF.
module modbus_rtu_request_framer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  req_type,
	input  logic [7:0]  slave_addr,
	input  logic [15:0] start_address,
	input  logic [15:0] quantity,
	input  logic [15:0] write_value,
	input  logic        coil_on,
	input  logic [15:0] data_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  frame_byte,
	output logic        last_byte,
	output logic        error
);

	logic          fq_valid;
	logic          fq_ready;
	mrf_pkg::job_t fq_job;
	logic          qb_valid;
	logic          qb_ready;
	mrf_pkg::job_t qb_job;

	mrf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.slave_addr    (slave_addr),
		.start_address (start_address),
		.quantity      (quantity),
		.write_value   (write_value),
		.coil_on       (coil_on),
		.data_word     (data_word),
		.job_valid     (fq_valid),
		.job_ready     (fq_ready),
		.job           (fq_job)
	);

	mrf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_data  (fq_job),
		.rd_valid (qb_valid),
		.rd_ready (qb_ready),
		.rd_data  (qb_job)
	);

	mrf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (qb_valid),
		.job_ready  (qb_ready),
		.job        (qb_job),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.frame_byte (frame_byte),
		.last_byte  (last_byte),
		.error      (error)
	);

endmodule
